FILE: rtl/edf_pkg.sv
`timescale 1ns / 1ps
package edf_pkg;

    localparam int unsigned IdW = 4;
    localparam int unsigned TimeW = 32;

    typedef enum logic [1:0] {
        REQ_CREATE    = 2'd0,
        REQ_TERMINATE = 2'd1,
        REQ_SLEEP     = 2'd2,
        REQ_TICK      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IdW-1:0]   task_id;
        logic [TimeW-1:0] task_deadline;
        logic [TimeW-1:0] delay_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             running_valid;
        logic [IdW-1:0]   running_task;
        logic [TimeW-1:0] running_deadline;
        logic [TimeW-1:0] tick_now;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture request, start
        logic scan_step;  // advance scan index, compare
        logic shift_step; // move one entry
        logic commit;     // final write / count update
        logic [2:0] op;   // operation selector
    } t_cmd;

    localparam logic [2:0] OP_RINS  = 3'd0; // insert into ready
    localparam logic [2:0] OP_RPOP  = 3'd1; // pop ready head
    localparam logic [2:0] OP_SINS  = 3'd2; // insert into sleep
    localparam logic [2:0] OP_SPOP  = 3'd3; // pop sleep head
    localparam logic [2:0] OP_NONE  = 3'd4;
    localparam logic [2:0] OP_RKEY  = 3'd5; // insert held key into ready

endpackage

FILE: rtl/edf_ready_and_timer_queues.sv
`timescale 1ns / 1ps
// EDF scheduler: ready queue sorted by deadline, sleep queue by wake time.
// Input channel i_in_valid / o_in_stall carries one request (create,
// terminate, sleep, tick) as a t_in transfer. Output channel o_out_valid /
// i_out_stall carries exactly one t_out result per request.
// One request at a time. Entries move serially: insert walks from the tail
// until its slot, a pop shifts the queue up one entry a cycle.
// Sleep costs a pop plus an insert; a tick costs a pop plus an insert for
// each woken task.
// The serial entry shifter of the datapath sets this cost.
// The result sits in an output register; the next request is taken as soon
// as the result is loaded, while the result may still wait under stall.
// A stalled result holds its value. Reset (synchronous, active low) empties
// both queues and clears the tick counter; queue entries are not cleared.
module edf_ready_and_timer_queues import edf_pkg::*; #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

    logic            load, op_go, op_busy, tick_inc, done, wake_due;
    logic [2:0]      op;
    logic [1:0]      st;
    logic [CntW-1:0] rcnt, scnt;
    t_out            res;
    t_out            res_st;
    logic            r_ovalid;
    t_out            r_odata;

    edf_ctrl #(.MaxTasks(MAX_TASKS), .CntW(CntW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_req_type(i_in_data.req_type),
        .i_op_busy(op_busy), .i_ready_count(rcnt), .i_sleep_count(scnt),
        .i_wake_due(wake_due), .i_out_busy(r_ovalid && i_out_stall),
        .o_in_stall, .o_load(load), .o_op_go(op_go), .o_op(op),
        .o_tick_inc(tick_inc), .o_done(done), .o_status(st)
    );

    edf_dp #(.MaxTasks(MAX_TASKS), .IdxW(IdxW), .CntW(CntW)) u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_req(i_in_data),
        .i_op_go(op_go), .i_op(op), .i_tick_inc(tick_inc),
        .o_op_busy(op_busy), .o_ready_count(rcnt), .o_sleep_count(scnt),
        .o_wake_due(wake_due), .o_res(res)
    );

    // Merge request status into the result
    always_comb begin
        res_st = res;
        res_st.status = st;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (done) begin
                r_ovalid <= 1'b1;
                r_odata <= res_st;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
endmodule

FILE: rtl/edf_dp.sv
`timescale 1ns / 1ps
module edf_dp import edf_pkg::*; #(
    parameter int unsigned MaxTasks = 16,
    parameter int unsigned IdxW = 4,
    parameter int unsigned CntW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_in               i_req,
    input  logic              i_op_go,
    input  logic [2:0]        i_op,
    input  logic              i_tick_inc,
    output logic              o_op_busy,
    output logic [CntW-1:0]   o_ready_count,
    output logic [CntW-1:0]   o_sleep_count,
    output logic              o_wake_due,
    output t_out              o_res
);
    // Queues as register arrays; each cycle moves one entry
    logic [IdW-1:0]   r_rid [MaxTasks];
    logic [TimeW-1:0] r_rdl [MaxTasks];
    logic [IdW-1:0]   r_sid [MaxTasks];
    logic [TimeW-1:0] r_swk [MaxTasks];
    logic [TimeW-1:0] r_sdl [MaxTasks];
    logic [CntW-1:0]  r_rcnt, r_scnt;
    logic [TimeW-1:0] r_tick;
    t_in              r_req;

    // Insert walks from the tail: shift down while key < entry
    logic             r_busy;
    logic [2:0]       r_op;
    logic [CntW-1:0]  r_pos;
    logic [IdW-1:0]   r_kid;
    logic [TimeW-1:0] r_kdl, r_kwk;

    logic [IdxW-1:0] pm1, pos_i;
    assign pm1   = IdxW'(r_pos - 1'b1);
    assign pos_i = r_pos[IdxW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0;
            r_scnt <= '0;
            r_tick <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_load) r_req <= i_req;
            if (i_tick_inc) r_tick <= r_tick + 1'b1;
            if (i_op_go) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                case (i_op)
                    OP_RINS: begin
                        r_pos <= r_rcnt;
                        r_kid <= r_req.task_id;
                        r_kdl <= r_req.task_deadline;
                    end
                    OP_RKEY: begin
                        // woken sleeper already captured in key by SPOP
                        r_pos <= r_rcnt;
                    end
                    OP_SINS: begin
                        // ready head already captured in key by RPOP
                        r_pos <= r_scnt;
                        r_kwk <= r_tick + r_req.delay_ticks;
                    end
                    OP_SPOP: begin
                        r_pos <= CntW'(1);
                        r_kid <= r_sid[0];
                        r_kdl <= r_sdl[0];
                    end
                    default: begin
                        r_pos <= CntW'(1);
                        r_kid <= r_rid[0];
                        r_kdl <= r_rdl[0];
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_RINS, OP_RKEY: begin
                        if (r_pos != 0 && r_kdl < r_rdl[pm1]) begin
                            r_rid[pos_i] <= r_rid[pm1];
                            r_rdl[pos_i] <= r_rdl[pm1];
                            r_pos <= r_pos - 1'b1;
                        end else begin
                            r_rid[pos_i] <= r_kid;
                            r_rdl[pos_i] <= r_kdl;
                            r_rcnt <= r_rcnt + 1'b1;
                            r_busy <= 1'b0;
                        end
                    end
                    OP_SINS: begin
                        if (r_pos != 0 && r_kwk < r_swk[pm1]) begin
                            r_sid[pos_i] <= r_sid[pm1];
                            r_swk[pos_i] <= r_swk[pm1];
                            r_sdl[pos_i] <= r_sdl[pm1];
                            r_pos <= r_pos - 1'b1;
                        end else begin
                            r_sid[pos_i] <= r_kid;
                            r_swk[pos_i] <= r_kwk;
                            r_sdl[pos_i] <= r_kdl;
                            r_scnt <= r_scnt + 1'b1;
                            r_busy <= 1'b0;
                        end
                    end
                    OP_SPOP: begin
                        if (r_pos < r_scnt) begin
                            r_sid[pm1] <= r_sid[pos_i];
                            r_swk[pm1] <= r_swk[pos_i];
                            r_sdl[pm1] <= r_sdl[pos_i];
                            r_pos <= r_pos + 1'b1;
                        end else begin
                            r_scnt <= r_scnt - 1'b1;
                            r_busy <= 1'b0;
                        end
                    end
                    default: begin
                        if (r_pos < r_rcnt) begin
                            r_rid[pm1] <= r_rid[pos_i];
                            r_rdl[pm1] <= r_rdl[pos_i];
                            r_pos <= r_pos + 1'b1;
                        end else begin
                            r_rcnt <= r_rcnt - 1'b1;
                            r_busy <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    assign o_op_busy     = r_busy;
    assign o_ready_count = r_rcnt;
    assign o_sleep_count = r_scnt;
    assign o_wake_due    = (r_scnt != 0) && (r_swk[0] <= r_tick);

    // Result fields from current state
    always_comb begin
        o_res = '0;
        o_res.status   = ST_OK;
        o_res.tick_now = r_tick;
        if (r_rcnt != 0) begin
            o_res.running_valid    = 1'b1;
            o_res.running_task     = r_rid[0];
            o_res.running_deadline = r_rdl[0];
        end
    end
endmodule

FILE: rtl/edf_ctrl.sv
`timescale 1ns / 1ps
module edf_ctrl import edf_pkg::*; #(
    parameter int unsigned MaxTasks = 16,
    parameter int unsigned CntW = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_req_type,
    input  logic            i_op_busy,
    input  logic [CntW-1:0] i_ready_count,
    input  logic [CntW-1:0] i_sleep_count,
    input  logic            i_wake_due,
    input  logic            i_out_busy,
    output logic            o_in_stall,
    output logic            o_load,
    output logic            o_op_go,
    output logic [2:0]      o_op,
    output logic            o_tick_inc,
    output logic            o_done,
    output logic [1:0]      o_status
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_OP1  = 6'b000100,
        S_OP2  = 6'b001000,
        S_WAKE = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_req, r_st;
    logic [1:0] n_st;
    logic [CntW:0] total;

    assign total = {1'b0, i_ready_count} + {1'b0, i_sleep_count};
    assign o_in_stall = (r_state != S_IDLE);
    assign o_load     = (r_state == S_IDLE) && i_in_valid;
    assign o_status   = r_st;

    always_comb begin
        n_state    = r_state;
        n_st       = r_st;
        o_op_go    = 1'b0;
        o_op       = OP_NONE;
        o_tick_inc = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                n_st = ST_OK;
                case (r_req)
                    REQ_CREATE: begin
                        if (total >= (CntW+1)'(MaxTasks)) begin
                            n_st = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            o_op_go = 1'b1;
                            o_op = OP_RINS;
                            n_state = S_OP2;
                        end
                    end
                    REQ_TICK: begin
                        o_tick_inc = 1'b1;
                        n_state = S_WAKE;
                    end
                    default: begin
                        if (i_ready_count == 0) begin
                            n_st = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            o_op_go = 1'b1;
                            o_op = OP_RPOP;
                            n_state = (r_req == REQ_SLEEP) ? S_OP1 : S_OP2;
                        end
                    end
                endcase
            end
            // Sleep: after pop, insert captured head into sleep queue
            S_OP1: if (!i_op_busy) begin
                o_op_go = 1'b1;
                o_op = OP_SINS;
                n_state = S_OP2;
            end
            S_OP2: if (!i_op_busy) n_state = (r_req == REQ_TICK) ? S_WAKE : S_DONE;
            // Wake: pop sleep head, then insert into ready
            S_WAKE: if (!i_op_busy) begin
                if (i_wake_due) begin
                    o_op_go = 1'b1;
                    o_op = OP_SPOP;
                    n_state = S_OP1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: if (!i_out_busy) begin
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // Wake path reuses OP1 for a ready insert
        if (r_state == S_OP1 && r_req == REQ_TICK && !i_op_busy) o_op = OP_RKEY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
            r_req   <= REQ_CREATE;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            if (o_load) r_req <= i_req_type;
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_go |-> !i_op_busy) else $error("op started while busy");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        total <= (CntW+1)'(MaxTasks)) else $error("store overfilled");
endmodule

FILE: tb/edf_ready_and_timer_queues_test.sv
`timescale 1ns / 1ps
module edf_ready_and_timer_queues_test;
    import edf_pkg::*;

    localparam int unsigned NTASK = 16;
    localparam int unsigned LIMIT_CYCLES = 1500000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    edf_ready_and_timer_queues #(.MAX_TASKS(NTASK)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    // scheduler shadow state
    logic [IdW-1:0]   rdy_id [NTASK];
    logic [TimeW-1:0] rdy_dl [NTASK];
    int unsigned      rdy_n;
    logic [IdW-1:0]   slp_id [NTASK];
    logic [TimeW-1:0] slp_wake [NTASK];
    logic [TimeW-1:0] slp_dl [NTASK];
    int unsigned      slp_n;
    logic [TimeW-1:0] ticks;

    t_in  pending_reqs[$];
    t_out expected_results[$];
    int   errors;
    int   cycle;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_recv;
    int   hold_cycles;
    bit   in_taken;

    function automatic void ready_insert(input logic [IdW-1:0] id,
                                         input logic [TimeW-1:0] dl);
        int pos;
        pos = 0;
        while (pos < rdy_n && !(dl < rdy_dl[pos])) pos++;
        for (int k = rdy_n; k > pos; k--) begin
            rdy_id[k] = rdy_id[k-1];
            rdy_dl[k] = rdy_dl[k-1];
        end
        rdy_id[pos] = id;
        rdy_dl[pos] = dl;
        rdy_n++;
    endfunction

    function automatic void ready_drop_head();
        for (int k = 1; k < rdy_n; k++) begin
            rdy_id[k-1] = rdy_id[k];
            rdy_dl[k-1] = rdy_dl[k];
        end
        rdy_n--;
    endfunction

    function automatic void sleep_insert(input logic [IdW-1:0] id,
                                         input logic [TimeW-1:0] wake,
                                         input logic [TimeW-1:0] dl);
        int pos;
        pos = 0;
        while (pos < slp_n && !(wake < slp_wake[pos])) pos++;
        for (int k = slp_n; k > pos; k--) begin
            slp_id[k] = slp_id[k-1];
            slp_wake[k] = slp_wake[k-1];
            slp_dl[k] = slp_dl[k-1];
        end
        slp_id[pos] = id;
        slp_wake[pos] = wake;
        slp_dl[pos] = dl;
        slp_n++;
    endfunction

    // compute the scheduler result for one request
    function automatic t_out schedule_request(input t_in rq);
        t_out r;
        logic [IdW-1:0]   hid;
        logic [TimeW-1:0] hdl;
        r = '0;
        r.status = ST_OK;
        case (t_req'(rq.req_type))
            REQ_CREATE: begin
                if (rdy_n + slp_n >= NTASK) r.status = ST_FULL;
                else ready_insert(rq.task_id, rq.task_deadline);
            end
            REQ_TERMINATE: begin
                if (rdy_n == 0) r.status = ST_EMPTY;
                else ready_drop_head();
            end
            REQ_SLEEP: begin
                if (rdy_n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hid = rdy_id[0];
                    hdl = rdy_dl[0];
                    ready_drop_head();
                    sleep_insert(hid, ticks + rq.delay_ticks, hdl);
                end
            end
            default: begin
                ticks = ticks + 1;
                while (slp_n > 0 && slp_wake[0] <= ticks) begin
                    hid = slp_id[0];
                    hdl = slp_dl[0];
                    for (int k = 1; k < slp_n; k++) begin
                        slp_id[k-1] = slp_id[k];
                        slp_wake[k-1] = slp_wake[k];
                        slp_dl[k-1] = slp_dl[k];
                    end
                    slp_n--;
                    ready_insert(hid, hdl);
                end
            end
        endcase
        if (rdy_n > 0) begin
            r.running_valid = 1'b1;
            r.running_task = rdy_id[0];
            r.running_deadline = rdy_dl[0];
        end
        r.tick_now = ticks;
        return r;
    endfunction

    function automatic t_in make_req(input t_req op, input logic [IdW-1:0] id,
                                     input logic [TimeW-1:0] dl, input logic [TimeW-1:0] dly);
        t_in q;
        q.req_type = op;
        q.task_id = id;
        q.task_deadline = dl;
        q.delay_ticks = dly;
        return q;
    endfunction

    function automatic t_in random_req();
        int sel;
        t_req op;
        logic [TimeW-1:0] dl;
        logic [TimeW-1:0] dly;
        sel = $urandom_range(0, 99);
        if (sel < 35) op = REQ_CREATE;
        else if (sel < 50) op = REQ_TERMINATE;
        else if (sel < 70) op = REQ_SLEEP;
        else op = REQ_TICK;
        // mostly near deadlines and short sleeps, so ties and wake-ups happen
        case ($urandom_range(0, 3))
            0: dl = $urandom;
            1: dl = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: dl = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 4))
            0: dly = $urandom;
            1: dly = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: dly = $urandom_range(0, 12);
        endcase
        return make_req(op, 4'($urandom), dl, dly);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("edf_ready_and_timer_queues_test: done, errors");
            $finish;
        end
    end

    // drive requests from the pending queue; advance only after a transfer
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_reqs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= hold_recv || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_out exp_r;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_results.push_back(schedule_request(i_in_data));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r !== o_out_data) begin
                    $display("%0t: mismatch exp st=%0d v=%0d id=%0d dl=%h tick=%h",
                             $time, exp_r.status, exp_r.running_valid, exp_r.running_task,
                             exp_r.running_deadline, exp_r.tick_now);
                    $display("%0t:          got st=%0d v=%0d id=%0d dl=%h tick=%h",
                             $time, o_out_data.status, o_out_data.running_valid,
                             o_out_data.running_task, o_out_data.running_deadline,
                             o_out_data.tick_now);
                    errors++;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1) hold_recv <= 1'b0;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        errors = 0;
        cycle = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        rdy_n = 0;
        slp_n = 0;
        ticks = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-queue errors, extremes, ties, fill to full, wake-ups
        pending_reqs.push_back(make_req(REQ_TERMINATE, 4'd0, '0, '0));
        pending_reqs.push_back(make_req(REQ_SLEEP, 4'd0, '0, '0));
        pending_reqs.push_back(make_req(REQ_CREATE, 4'hF, 32'hFFFF_FFFF, '1));
        pending_reqs.push_back(make_req(REQ_CREATE, 4'h0, 32'h0, '0));
        pending_reqs.push_back(make_req(REQ_CREATE, 4'h5, 32'h0, '0));
        pending_reqs.push_back(make_req(REQ_SLEEP, 4'h0, '0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(REQ_SLEEP, 4'h0, '0, 32'd2));
        pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0));
        pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0));
        pending_reqs.push_back(make_req(REQ_TERMINATE, '0, '0, '0));
        for (int i = 0; i < 16; i++)
            pending_reqs.push_back(make_req(REQ_CREATE, 4'(i), 32'(i % 3), '0));
        drain();

        // random phases with varying idle and stall
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                3: begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                hold_recv = 1'b1;
                hold_cycles = 3000;
            end
            for (int i = 0; i < 215; i++) pending_reqs.push_back(random_req());
            // sender waits for every result before the next phase
            drain();
        end

        // wake-time wrap: sleep a task with the largest delay, so its wake time wraps
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pending_reqs.push_back(make_req(REQ_CREATE, 4'h3, 32'd7, '0));
        pending_reqs.push_back(make_req(REQ_SLEEP, '0, '0, 32'hFFFF_FFFF));
        for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0));
        drain();
        repeat (200) @(posedge i_clk);

        if (errors == 0) begin
            $display("edf_ready_and_timer_queues_test: done, clean");
        end else begin
            $display("edf_ready_and_timer_queues_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: edf_ready_and_timer_queues.f
rtl/edf_pkg.sv
rtl/edf_dp.sv
rtl/edf_ctrl.sv
rtl/edf_ready_and_timer_queues.sv
tb/edf_ready_and_timer_queues_test.sv
